[rtl/core/apop_pkg.sv]
// apop_pkg: shared types, fixed-point constants and the output clamp
// for the arm-plane orientation projector; depends on nothing

package apop_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 18;
  localparam int SUM_W     = 28;

  localparam int ONE     = 1 << FRAC_BITS;
  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  typedef logic signed [IN_W-1:0]  in_t;
  typedef logic signed [OUT_W-1:0] out_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // clamp a wide signed sum into the output range
  function automatic out_t sat_out(sum_t v);
    if (v > SUM_W'(OUT_MAX)) begin
      sat_out = OUT_W'(OUT_MAX);
    end else if (v < SUM_W'(OUT_MIN)) begin
      sat_out = OUT_W'(OUT_MIN);
    end else begin
      sat_out = v[OUT_W-1:0];
    end
  endfunction

endpackage

[rtl/core/arm_plane_orientation_projector_top.sv]
// Arm-plane orientation projector: takes the goal Y and Z columns (Q1.14) and
// returns the orientation projected into the arm plane (normal (0,-1,0)) as
// three Q3.14 axes, with y' rotated by Rodrigues' formula and x' = y' x z'.
// One beat is accepted every cycle while the output is not stalled. The
// pipeline has four dependent multiplier stages (the products for cos, then
// sin and the (1 - cos) term, then their products with k, then the final
// cross product), a stage forming cos, and two summing and clamping stages,
// the last being the output register. Backpressure stalls the pipeline in place, with no loss.
// Uses apop_pkg, apop_rot and apop_xprod.

module arm_plane_orientation_projector_top
  import apop_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  y_col_x,
  input  in_t  y_col_y,
  input  in_t  y_col_z,
  input  in_t  z_col_x,
  input  in_t  z_col_y,
  input  in_t  z_col_z,
  output logic out_valid,
  input  logic out_ready,
  output out_t new_x_x,
  output out_t new_x_y,
  output out_t new_x_z,
  output out_t new_y_x,
  output out_t new_y_y,
  output out_t new_y_z,
  output out_t new_z_x,
  output out_t new_z_y,
  output out_t new_z_z
);

  logic mid_valid;
  logic mid_ready;
  out_t mid_yx, mid_yy, mid_yz;
  in_t  mid_zx, mid_zz;

  apop_rot u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .yx        (y_col_x),
    .yy        (y_col_y),
    .yz        (y_col_z),
    .zx        (z_col_x),
    .zy        (z_col_y),
    .zz        (z_col_z),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .nyx       (mid_yx),
    .nyy       (mid_yy),
    .nyz       (mid_yz),
    .zx_o      (mid_zx),
    .zz_o      (mid_zz)
  );

  apop_xprod u_xprod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .nyx       (mid_yx),
    .nyy       (mid_yy),
    .nyz       (mid_yz),
    .zx        (mid_zx),
    .zz        (mid_zz),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_x_x   (new_x_x),
    .new_x_y   (new_x_y),
    .new_x_z   (new_x_z),
    .new_y_x   (new_y_x),
    .new_y_y   (new_y_y),
    .new_y_z   (new_y_z),
    .new_z_x   (new_z_x),
    .new_z_z   (new_z_z)
  );

  // projected z axis has no component along the plane normal
  assign new_z_y = '0;

endmodule

[rtl/core/apop_rot.sv]
// apop_rot: five-stage pipeline from the goal Y and Z columns to the
// rotated Y axis (Rodrigues form); uses apop_pkg

module apop_rot
  import apop_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  yx,
  input  in_t  yy,
  input  in_t  yz,
  input  in_t  zx,
  input  in_t  zy,
  input  in_t  zz,
  output logic out_valid,
  input  logic out_ready,
  output out_t nyx,
  output out_t nyy,
  output out_t nyz,
  output in_t  zx_o,
  output in_t  zz_o
);

  localparam int NST  = 5;
  localparam int M1_W = 2 * IN_W;
  localparam int Q1_W = M1_W - FRAC_BITS;
  localparam int C_W  = Q1_W + 1;
  localparam int M3A_W = IN_W + C_W;
  localparam int Q3A_W = M3A_W - FRAC_BITS;
  localparam int M3B_W = 2 * C_W;
  localparam int Q3B_W = M3B_W - FRAC_BITS;
  localparam int K_W   = IN_W + 1;
  localparam int M4X_W = Q3A_W + Q1_W;
  localparam int Q4X_W = M4X_W - FRAC_BITS;
  localparam int M4Y_W = Q3A_W + C_W;
  localparam int Q4Y_W = M4Y_W - FRAC_BITS;
  localparam int M4K_W = Q3B_W + K_W;
  localparam int Q4K_W = M4K_W - FRAC_BITS;
  localparam int M4Z_W = Q3B_W + IN_W;
  localparam int Q4Z_W = M4Z_W - FRAC_BITS;

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // stage handshake: a stage loads when empty or when its content moves on
  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // stage 1: eight component products
  logic signed [M1_W-1:0] m_zxzx, m_zzzz, m_zxyy, m_zxyx, m_zzyz, m_zzyy, m_zxyz, m_zzyx;
  logic signed [Q1_W-1:0] q_zxzx, q_zzzz, q_zxyy, q_zxyx, q_zzyz, q_zzyy, q_zxyz, q_zzyx;
  in_t s1_yx, s1_yy, s1_yz, s1_zx, s1_zy, s1_zz;

  always_comb begin
    m_zxzx = zx * zx;
    m_zzzz = zz * zz;
    m_zxyy = zx * yy;
    m_zxyx = zx * yx;
    m_zzyz = zz * yz;
    m_zzyy = zz * yy;
    m_zxyz = zx * yz;
    m_zzyx = zz * yx;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_zxzx <= m_zxzx[M1_W-1:FRAC_BITS];
      q_zzzz <= m_zzzz[M1_W-1:FRAC_BITS];
      q_zxyy <= m_zxyy[M1_W-1:FRAC_BITS];
      q_zxyx <= m_zxyx[M1_W-1:FRAC_BITS];
      q_zzyz <= m_zzyz[M1_W-1:FRAC_BITS];
      q_zzyy <= m_zzyy[M1_W-1:FRAC_BITS];
      q_zxyz <= m_zxyz[M1_W-1:FRAC_BITS];
      q_zzyx <= m_zzyx[M1_W-1:FRAC_BITS];
      s1_yx  <= yx;
      s1_yy  <= yy;
      s1_yz  <= yz;
      s1_zx  <= zx;
      s1_zy  <= zy;
      s1_zz  <= zz;
    end
  end

  // stage 2: cos, k x y, k . y
  logic signed [C_W-1:0]  c2, cy2, kdy2;
  logic signed [Q1_W-1:0] cx2, cz2;
  in_t s2_yx, s2_yy, s2_yz, s2_zx, s2_zy, s2_zz;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c2    <= C_W'(q_zxzx) + C_W'(q_zzzz);
      cy2   <= C_W'(q_zxyx) + C_W'(q_zzyz);
      kdy2  <= C_W'(q_zxyz) - C_W'(q_zzyx);
      cx2   <= -q_zxyy;
      cz2   <= -q_zzyy;
      s2_yx <= s1_yx;
      s2_yy <= s1_yy;
      s2_yz <= s1_yz;
      s2_zx <= s1_zx;
      s2_zy <= s1_zy;
      s2_zz <= s1_zz;
    end
  end

  // stage 3: sin before sign, (1 - cos) * k.y, cos * y
  logic signed [C_W-1:0]   omc;
  logic signed [M3A_W-1:0] m_zyc, m_cyx, m_cyy, m_cyz;
  logic signed [M3B_W-1:0] m_w;
  logic signed [Q3A_W-1:0] zyc3, cyx3, cyy3, cyz3;
  logic signed [Q3B_W-1:0] w3;
  logic signed [Q1_W-1:0]  cx3, cz3;
  logic signed [C_W-1:0]   cy3;
  in_t s3_zx, s3_zz;

  always_comb begin
    omc   = C_W'(ONE) - c2;
    m_zyc = s2_zy * c2;
    m_w   = omc * kdy2;
    m_cyx = c2 * s2_yx;
    m_cyy = c2 * s2_yy;
    m_cyz = c2 * s2_yz;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      zyc3  <= m_zyc[M3A_W-1:FRAC_BITS];
      w3    <= m_w[M3B_W-1:FRAC_BITS];
      cyx3  <= m_cyx[M3A_W-1:FRAC_BITS];
      cyy3  <= m_cyy[M3A_W-1:FRAC_BITS];
      cyz3  <= m_cyz[M3A_W-1:FRAC_BITS];
      cx3   <= cx2;
      cy3   <= cy2;
      cz3   <= cz2;
      s3_zx <= s2_zx;
      s3_zz <= s2_zz;
    end
  end

  // stage 4: sin * (k x y) and w * k
  logic signed [Q3A_W-1:0] sn;
  logic signed [K_W-1:0]   kx;
  logic signed [M4X_W-1:0] m_scx, m_scz;
  logic signed [M4Y_W-1:0] m_scy;
  logic signed [M4K_W-1:0] m_wkx;
  logic signed [M4Z_W-1:0] m_wkz;
  logic signed [Q4X_W-1:0] scx4, scz4;
  logic signed [Q4Y_W-1:0] scy4;
  logic signed [Q4K_W-1:0] wkx4;
  logic signed [Q4Z_W-1:0] wkz4;
  logic signed [Q3A_W-1:0] cyx4, cyy4, cyz4;
  in_t s4_zx, s4_zz;

  always_comb begin
    sn    = -zyc3;
    kx    = -(K_W'(s3_zz));
    m_scx = sn * cx3;
    m_scy = sn * cy3;
    m_scz = sn * cz3;
    m_wkx = w3 * kx;
    m_wkz = w3 * s3_zx;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      scx4  <= m_scx[M4X_W-1:FRAC_BITS];
      scy4  <= m_scy[M4Y_W-1:FRAC_BITS];
      scz4  <= m_scz[M4X_W-1:FRAC_BITS];
      wkx4  <= m_wkx[M4K_W-1:FRAC_BITS];
      wkz4  <= m_wkz[M4Z_W-1:FRAC_BITS];
      cyx4  <= cyx3;
      cyy4  <= cyy3;
      cyz4  <= cyz3;
      s4_zx <= s3_zx;
      s4_zz <= s3_zz;
    end
  end

  // stage 5: sum and clamp
  sum_t sum_x, sum_y, sum_z;

  always_comb begin
    sum_x = SUM_W'(cyx4) + SUM_W'(scx4) + SUM_W'(wkx4);
    sum_y = SUM_W'(cyy4) + SUM_W'(scy4);
    sum_z = SUM_W'(cyz4) + SUM_W'(scz4) + SUM_W'(wkz4);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      nyx  <= sat_out(sum_x);
      nyy  <= sat_out(sum_y);
      nyz  <= sat_out(sum_z);
      zx_o <= s4_zx;
      zz_o <= s4_zz;
    end
  end

endmodule

[rtl/core/apop_xprod.sv]
// apop_xprod: two-stage pipeline forming x' = y' x z' with z' = (zx, 0, zz);
// its second stage is the output register; uses apop_pkg

module apop_xprod
  import apop_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  out_t nyx,
  input  out_t nyy,
  input  out_t nyz,
  input  in_t  zx,
  input  in_t  zz,
  output logic out_valid,
  input  logic out_ready,
  output out_t new_x_x,
  output out_t new_x_y,
  output out_t new_x_z,
  output out_t new_y_x,
  output out_t new_y_y,
  output out_t new_y_z,
  output out_t new_z_x,
  output out_t new_z_z
);

  localparam int M_W = OUT_W + IN_W;
  localparam int Q_W = M_W - FRAC_BITS;

  logic [1:0] v;
  logic [1:0] en;

  assign en[1]     = !v[1] || out_ready;
  assign en[0]     = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
    end
  end

  // stage 1: four cross-product terms
  logic signed [M_W-1:0] m_yyzz, m_yzzx, m_yxzz, m_yyzx;
  logic signed [Q_W-1:0] q_yyzz, q_yzzx, q_yxzz, q_yyzx;
  out_t s1_yx, s1_yy, s1_yz;
  in_t  s1_zx, s1_zz;

  always_comb begin
    m_yyzz = nyy * zz;
    m_yzzx = nyz * zx;
    m_yxzz = nyx * zz;
    m_yyzx = nyy * zx;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q_yyzz <= m_yyzz[M_W-1:FRAC_BITS];
      q_yzzx <= m_yzzx[M_W-1:FRAC_BITS];
      q_yxzz <= m_yxzz[M_W-1:FRAC_BITS];
      q_yyzx <= m_yyzx[M_W-1:FRAC_BITS];
      s1_yx  <= nyx;
      s1_yy  <= nyy;
      s1_yz  <= nyz;
      s1_zx  <= zx;
      s1_zz  <= zz;
    end
  end

  // stage 2: combine, clamp, output beat
  sum_t sum_x, sum_y, sum_z;

  always_comb begin
    sum_x = SUM_W'(q_yyzz);
    sum_y = SUM_W'(q_yzzx) - SUM_W'(q_yxzz);
    sum_z = -SUM_W'(q_yyzx);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      new_x_x <= sat_out(sum_x);
      new_x_y <= sat_out(sum_y);
      new_x_z <= sat_out(sum_z);
      new_y_x <= s1_yx;
      new_y_y <= s1_yy;
      new_y_z <= s1_yz;
      new_z_x <= OUT_W'(s1_zx);
      new_z_z <= OUT_W'(s1_zz);
    end
  end

endmodule
